// ----- rtl/utf8_stream_validator_defines.svh -----
// Assertion macros shared by the checking code of the validator
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define UTF8V_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8v check failed");

// Check that the consequent holds in the cycle after the antecedent
`define UTF8V_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8v check failed");

`endif

// ----- rtl/utf8v_pkg.sv -----
package utf8v_pkg;

   // Width of the character counters; saturate at all ones
   localparam int COUNT_WIDTH = 32;
   localparam int POINT_WIDTH = 21;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_END      = 3'd1,
      ERR_TAIL     = 3'd2,
      ERR_OVERLONG = 3'd3,
      ERR_INVALID  = 3'd4,
      ERR_HEADER   = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      DONE_NONE  = 2'd0,
      DONE_ASCII = 2'd1,
      DONE_MULTI = 2'd2
   } done_type;

   // Decoder state carried between words
   typedef struct packed {
      logic [1:0]             tail_remaining;
      logic [1:0]             sequence_length;
      logic [POINT_WIDTH-1:0] point_acc;
      err_type                sticky_error;
      logic                   finished;
   } dec_state_type;

   // Per-word outcome of the decoder
   typedef struct packed {
      done_type done;
      logic     inc_ascii;
      logic     inc_multi;
   } dec_event_type;

endpackage

// ----- rtl/utf8v_step.sv -----
module utf8v_step (
   input  utf8v_pkg::dec_state_type cur_state,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_stream,
   output utf8v_pkg::dec_state_type nxt_state,
   output utf8v_pkg::dec_event_type evt
);
   import utf8v_pkg::*;

   logic [POINT_WIDTH-1:0] shifted_acc;
   err_type                final_err;

   // Fold the six payload bits of a tail byte into the accumulator
   assign shifted_acc = {cur_state.point_acc[POINT_WIDTH-7:0], data_byte[5:0]};

   // Range checks on a completed multibyte point, by number of tail bytes
   always_comb begin
      final_err = ERR_NONE;
      case (cur_state.sequence_length)
         2'd1: begin
            if (shifted_acc < 21'h00_0080) final_err = ERR_OVERLONG;
         end
         2'd2: begin
            if (shifted_acc >= 21'h00_D800 && shifted_acc <= 21'h00_DFFF)
               final_err = ERR_INVALID;
            else if (shifted_acc < 21'h00_0800)
               final_err = ERR_OVERLONG;
         end
         default: begin
            if (shifted_acc > 21'h10_FFFF)
               final_err = ERR_INVALID;
            else if (shifted_acc < 21'h01_0000)
               final_err = ERR_OVERLONG;
         end
      endcase
   end

   // Advance the decoder by one word; hold everything once stopped
   always_comb begin
      nxt_state     = cur_state;
      evt.done      = DONE_NONE;
      evt.inc_ascii = 1'b0;
      evt.inc_multi = 1'b0;
      if (cur_state.sticky_error == ERR_NONE && !cur_state.finished) begin
         if (end_of_stream) begin
            if (cur_state.tail_remaining != 2'd0)
               nxt_state.sticky_error = ERR_END;
            else
               nxt_state.finished = 1'b1;
         end else if (cur_state.tail_remaining == 2'd0) begin
            // Decode a header byte
            if (!data_byte[7]) begin
               nxt_state.point_acc = {{(POINT_WIDTH-8){1'b0}}, data_byte};
               evt.inc_ascii       = 1'b1;
               evt.done            = DONE_ASCII;
            end else if (data_byte[7:5] == 3'b110) begin
               nxt_state.point_acc       = {{(POINT_WIDTH-5){1'b0}}, data_byte[4:0]};
               nxt_state.sequence_length = 2'd1;
               nxt_state.tail_remaining  = 2'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
               nxt_state.point_acc       = {{(POINT_WIDTH-4){1'b0}}, data_byte[3:0]};
               nxt_state.sequence_length = 2'd2;
               nxt_state.tail_remaining  = 2'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
               nxt_state.point_acc       = {{(POINT_WIDTH-3){1'b0}}, data_byte[2:0]};
               nxt_state.sequence_length = 2'd3;
               nxt_state.tail_remaining  = 2'd3;
            end else begin
               nxt_state.sticky_error = ERR_HEADER;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            nxt_state.sticky_error = ERR_TAIL;
         end else begin
            // Take a tail byte; check the point on the last one
            nxt_state.point_acc      = shifted_acc;
            nxt_state.tail_remaining = cur_state.tail_remaining - 2'd1;
            if (cur_state.tail_remaining == 2'd1) begin
               nxt_state.sequence_length = 2'd0;
               if (final_err != ERR_NONE) begin
                  nxt_state.sticky_error = final_err;
               end else begin
                  evt.inc_multi = 1'b1;
                  evt.done      = DONE_MULTI;
               end
            end
         end
      end
   end

endmodule

// ----- rtl/utf8v_count.sv -----
module utf8v_count (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              inc,
   output logic [utf8v_pkg::COUNT_WIDTH-1:0] value
);
   import utf8v_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   // Advance unless already at all ones
   always_comb begin
      count_in = count_ff;
      if (inc && count_ff != {COUNT_WIDTH{1'b1}})
         count_in = count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

   assign value = count_ff;

endmodule

// ----- rtl/utf8_stream_validator.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_data_byte, req_end_of_stream
// rsp_      out        rsp_valid/rsp_ready  rsp_char_done, rsp_error_code, rsp_code_point,
//                                           rsp_ascii_count, rsp_multibyte_count,
//                                           rsp_stream_done
//
// One word in, one word out; a word is accepted every cycle while req_ready is high,
// and its result appears in the next cycle from the decoder state registers.
// req_ready is high whenever the result slot is empty or is taken this cycle,
// so a stalled consumer holds the decoder state and the result together.
// Synchronous reset clears the decoder state, both counters and the result slot.
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_char_done,
   output logic [2:0]  rsp_error_code,
   output logic [20:0] rsp_code_point,
   output logic [31:0] rsp_ascii_count,
   output logic [31:0] rsp_multibyte_count,
   output logic        rsp_stream_done
);
   import utf8v_pkg::*;

   dec_state_type          state_ff;
   dec_state_type          state_in;
   dec_event_type          evt;
   done_type               done_ff;
   logic                   rsp_valid_ff;
   logic                   accept;
   logic [COUNT_WIDTH-1:0] ascii_total;
   logic [COUNT_WIDTH-1:0] multi_total;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   utf8v_step u_step (
      .cur_state     (state_ff),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .nxt_state     (state_in),
      .evt           (evt)
   );

   utf8v_count u_ascii_count (
      .clock (clock),
      .reset (reset),
      .inc   (accept && evt.inc_ascii),
      .value (ascii_total)
   );

   utf8v_count u_multi_count (
      .clock (clock),
      .reset (reset),
      .inc   (accept && evt.inc_multi),
      .value (multi_total)
   );

   // Update decoder state and result slot on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         done_ff      <= DONE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            done_ff  <= evt.done;
         end
         if (accept)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_char_done       = done_ff;
   assign rsp_error_code      = state_ff.sticky_error;
   assign rsp_code_point      = state_ff.point_acc;
   assign rsp_ascii_count     = 32'(ascii_total);
   assign rsp_multibyte_count = 32'(multi_total);
   assign rsp_stream_done     = state_ff.finished;

   // Checks on the decoder
   `UTF8V_ASSERT_NEXT(a_error_sticky, clock, reset,
      rsp_error_code != ERR_NONE, $stable(rsp_error_code))
   `UTF8V_ASSERT_NEXT(a_done_sticky, clock, reset, rsp_stream_done, rsp_stream_done)
   `UTF8V_ASSERT_SAME(a_done_clean, clock, reset, rsp_stream_done, rsp_error_code == ERR_NONE)
   `UTF8V_ASSERT_SAME(a_char_clean, clock, reset,
      rsp_valid && rsp_char_done != DONE_NONE, rsp_error_code == ERR_NONE)
   `UTF8V_ASSERT_SAME(a_ascii_range, clock, reset,
      rsp_valid && rsp_char_done == DONE_ASCII, rsp_code_point < 21'h00_0080)

endmodule

// ----- test/utf8_stream_validator_tb.sv -----
`timescale 1ns / 100ps

module utf8_stream_validator_tb;
   import utf8v_pkg::*;

   // One result word as seen on the rsp_ channel
   typedef struct packed {
      logic [1:0]  done;
      logic [2:0]  fault;
      logic [20:0] point;
      logic [31:0] ascii;
      logic [31:0] multi;
      logic        closed;
   } char_report_type;

   // Ways the single stream of the run is brought to its end
   typedef enum int {
      CLOSE_CLEAN,
      CLOSE_EARLY_END,
      CLOSE_BAD_HEADER,
      CLOSE_BAD_TAIL,
      CLOSE_OVERLONG_2,
      CLOSE_OVERLONG_3,
      CLOSE_OVERLONG_4,
      CLOSE_SURROGATE,
      CLOSE_ABOVE_MAX
   } closing_kind_type;

   class utf8_scoreboard;
      logic [1:0]             tails_left;
      logic [1:0]             seq_tails;
      logic [20:0]            point;
      logic [COUNT_WIDTH-1:0] ascii_total;
      logic [COUNT_WIDTH-1:0] multi_total;
      err_type                fault;
      logic                   closed;
      char_report_type        pending[$];
      int                     mismatches;

      function new();
         tails_left  = '0;
         seq_tails   = '0;
         point       = '0;
         ascii_total = '0;
         multi_total = '0;
         fault       = ERR_NONE;
         closed      = 1'b0;
         mismatches  = 0;
      endfunction

      // Saturate at all ones
      function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      // Classify a completed multibyte point by its number of tail bytes
      function err_type range_fault(logic [1:0] tails, logic [20:0] cp);
         case (tails)
            2'd1: begin
               if (cp < 21'h80) return ERR_OVERLONG;
            end
            2'd2: begin
               if (cp >= 21'hD800 && cp <= 21'hDFFF) return ERR_INVALID;
               if (cp < 21'h800) return ERR_OVERLONG;
            end
            default: begin
               if (cp > 21'h10FFFF) return ERR_INVALID;
               if (cp < 21'h10000) return ERR_OVERLONG;
            end
         endcase
         return ERR_NONE;
      endfunction

      // Advance the decoder by one accepted word and queue the result it gives
      function void note_word(logic [7:0] b, logic eos);
         char_report_type r;
         err_type         e;
         done_type        done;
         done = DONE_NONE;
         if (fault == ERR_NONE && !closed) begin
            if (eos) begin
               if (tails_left != 2'd0) fault = ERR_END;
               else closed = 1'b1;
            end else if (tails_left == 2'd0) begin
               if (b[7] == 1'b0) begin
                  point       = {13'd0, b};
                  ascii_total = bump(ascii_total);
                  done        = DONE_ASCII;
               end else if (b[7:5] == 3'b110) begin
                  point      = {16'd0, b[4:0]};
                  seq_tails  = 2'd1;
                  tails_left = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  point      = {17'd0, b[3:0]};
                  seq_tails  = 2'd2;
                  tails_left = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  point      = {18'd0, b[2:0]};
                  seq_tails  = 2'd3;
                  tails_left = 2'd3;
               end else begin
                  fault = ERR_HEADER;
               end
            end else if (b[7:6] != 2'b10) begin
               fault = ERR_TAIL;
            end else begin
               point      = {point[14:0], b[5:0]};
               tails_left = tails_left - 2'd1;
               if (tails_left == 2'd0) begin
                  e         = range_fault(seq_tails, point);
                  seq_tails = 2'd0;
                  if (e != ERR_NONE) begin
                     fault = e;
                  end else begin
                     multi_total = bump(multi_total);
                     done        = DONE_MULTI;
                  end
               end
            end
         end
         r.done   = done;
         r.fault  = fault;
         r.point  = point;
         r.ascii  = 32'(ascii_total);
         r.multi  = 32'(multi_total);
         r.closed = closed;
         pending.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      // Match a result word against the oldest expectation
      function void check_result(char_report_type got);
         char_report_type want;
         if (pending.size() == 0) begin
            $error("result word with no expectation waiting");
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("char_done", 32'(want.done), 32'(got.done));
         compare_field("error_code", 32'(want.fault), 32'(got.fault));
         compare_field("code_point", 32'(want.point), 32'(got.point));
         compare_field("ascii_count", want.ascii, got.ascii);
         compare_field("multibyte_count", want.multi, got.multi);
         compare_field("stream_done", 32'(want.closed), 32'(got.closed));
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   localparam int RESET_CYCLES  = 5;
   localparam int TOTAL_WORDS   = 1620;
   localparam int CALM_AFTER    = 1400;
   localparam int PRESSURE_AT   = 600;
   localparam int PRESSURE_HOLD = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int NOISE_WORDS   = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_char_done;
   logic [2:0]  rsp_error_code;
   logic [20:0] rsp_code_point;
   logic [31:0] rsp_ascii_count;
   logic [31:0] rsp_multibyte_count;
   logic        rsp_stream_done;

   utf8_scoreboard board = new();
   int unsigned    words_sent = 0;
   bit             calm = 1'b0;
   bit             pressure_done = 1'b0;

   utf8_stream_validator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_char_done       (rsp_char_done),
      .rsp_error_code      (rsp_error_code),
      .rsp_code_point      (rsp_code_point),
      .rsp_ascii_count     (rsp_ascii_count),
      .rsp_multibyte_count (rsp_multibyte_count),
      .rsp_stream_done     (rsp_stream_done)
   );

   always #5 clock = ~clock;

   // Idle in alternating stretches of words, and never near the end
   function automatic bit idling_on();
      return !calm && ((words_sent / 100) % 2 == 0);
   endfunction

   // Offer one word, after an optional gap, and hold it until taken
   task automatic send_word(input logic [7:0] b, input logic eos);
      int gap;
      if (idling_on() && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Send the first count bytes of cp encoded in nbytes bytes
   task automatic send_prefix(input logic [20:0] cp, input int nbytes, input int count);
      logic [7:0] enc [4];
      enc[0] = 8'd0;
      enc[1] = 8'd0;
      enc[2] = 8'd0;
      enc[3] = 8'd0;
      case (nbytes)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < count; i++) send_word(enc[i], 1'b0);
   endtask

   task automatic send_char(input logic [20:0] cp, input int nbytes);
      send_prefix(cp, nbytes, nbytes);
   endtask

   // Pick a well-formed character of random length and value
   task automatic send_random_char();
      logic [20:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_char(21'($urandom_range(0, 21'h7F)), 1);
         4, 5: send_char(21'($urandom_range(21'h80, 21'h7FF)), 2);
         6, 7: begin
            // skip the surrogate range
            cp = 21'($urandom_range(21'h800, 21'hF7FF));
            if (cp >= 21'hD800) cp = cp + 21'h800;
            send_char(cp, 3);
         end
         default: send_char(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      endcase
   endtask

   // Finish the stream with a clean end mark or with one of the error kinds
   task automatic send_closing();
      closing_kind_type kind;
      int               n;
      logic [7:0]       b;
      kind = closing_kind_type'($urandom_range(CLOSE_CLEAN, CLOSE_ABOVE_MAX));
      n    = $urandom_range(2, 4);
      case (kind)
         CLOSE_CLEAN: send_word(8'($urandom_range(0, 255)), 1'b1);
         CLOSE_EARLY_END: begin
            send_prefix(21'($urandom), n, $urandom_range(1, n - 1));
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
         CLOSE_BAD_HEADER: begin
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h80, 8'hBF));
            else b = 8'($urandom_range(8'hF8, 8'hFF));
            send_word(b, 1'b0);
         end
         CLOSE_BAD_TAIL: begin
            send_prefix(21'($urandom), n, $urandom_range(1, n - 1));
            // anything but 10xxxxxx
            b = 8'($urandom_range(0, 191));
            if (b >= 8'h80) b = b + 8'h40;
            send_word(b, 1'b0);
         end
         CLOSE_OVERLONG_2: send_char(21'($urandom_range(0, 21'h7F)), 2);
         CLOSE_OVERLONG_3: send_char(21'($urandom_range(0, 21'h7FF)), 3);
         CLOSE_OVERLONG_4: send_char(21'($urandom_range(0, 21'hFFFF)), 4);
         CLOSE_SURROGATE: send_char(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
         default: send_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      endcase
   endtask

   // Note accepted input words and check accepted result words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_word(req_data_byte, req_end_of_stream);
         if (rsp_valid && rsp_ready) begin
            board.check_result({rsp_char_done, rsp_error_code, rsp_code_point,
                                rsp_ascii_count, rsp_multibyte_count, rsp_stream_done});
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off to fill the block
   initial begin : receiver
      int burst;
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && words_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(posedge clock);
         end else if (idling_on() && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Give up when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // range edges of each sequence length but the top of the three-byte range, either side of the surrogates
      send_char(21'h0, 1);
      send_char(21'h7F, 1);
      send_char(21'h80, 2);
      send_char(21'h7FF, 2);
      send_char(21'h800, 3);
      send_char(21'hD7FF, 3);
      send_char(21'hE000, 3);
      send_char(21'h10000, 4);
      send_char(21'h10FFFF, 4);

      // well-formed random text
      while (words_sent < TOTAL_WORDS) begin
         if (words_sent >= CALM_AFTER) calm = 1'b1;
         send_random_char();
      end
      calm = 1'b1;

      // close the stream, then check that later words are dropped
      send_closing();
      repeat (NOISE_WORDS) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
